// ----- src/tof_pkg.sv -----
// Shared types and constants for the telnet output filter.
// No dependencies; imported by every module of the block.
package tof_pkg;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CMD_IAC  = 8'hFF;
    localparam logic [7:0] CMD_WILL = 8'hFB;
    localparam logic [7:0] CMD_WONT = 8'hFC;
    localparam logic [7:0] CMD_DO   = 8'hFD;
    localparam logic [7:0] CMD_DONT = 8'hFE;
    localparam logic [7:0] OPT_ECHO = 8'h01;

    localparam logic [1:0] ECHO_NONE = 2'd0;
    localparam logic [1:0] ECHO_ON   = 2'd1;
    localparam logic [1:0] ECHO_OFF  = 2'd2;

    localparam logic       CFG_TELNET_MODE = 1'b0;
    localparam logic       CFG_MAX_LINE    = 1'b1;
    localparam logic [7:0] MAX_LINE_RESET  = 8'd250;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // One classified item between front and back
    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic [1:0] echo_request;
        logic       add_lf;
    } tof_entry_t;

endpackage

// ----- src/telnet_output_filter_unit.sv -----
// Top level of the telnet output filter: front end, queue and back end.
// Depends on tof_pkg, tof_front, tof_queue and tof_back.
//
// Usage:
//   Input channel s_valid/s_ready/s_in_byte carries the byte stream. The output
//   channel m_valid/m_ready carries results: m_out_byte with m_has_byte, an
//   echo request on m_echo_request (1 on, 2 off), and m_last on the final
//   result of an input byte. Telnet commands other than DO ECHO and DONT ECHO,
//   and a NUL or LF after CR, produce no result at all.
//   Configuration: cfg_we writes cfg_wdata to register cfg_index (0 telnet
//   mode, 1 maximum line length); write only while idle.
//   A taken byte is written into the queue and then into the output register.
//   Throughput: one byte per cycle while the output is not stalled; a byte
//   that hits the line limit yields two results, the second carrying the
//   inserted LF. The two-entry queue between front and back absorbs that
//   extra result and short output stalls. When m_ready stays low the output
//   register holds, the queue fills and s_ready drops once it is full. s_ready
//   depends only on queue occupancy.
//   Reset (aresetn low, synchronous) empties the queue and output, puts the
//   parser in the data state, clears the line count and previous byte, and
//   restores telnet mode off and a line limit of 250.
module telnet_output_filter_unit (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_wdata,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_has_byte,
    output logic [1:0] m_echo_request,
    output logic       m_last
);
    import tof_pkg::*;

    logic       push, push_ready, pop, pop_valid;
    tof_entry_t push_entry, pop_entry;

    tof_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_in_byte (s_in_byte),
        .q_ready   (push_ready),
        .q_push    (push),
        .q_entry   (push_entry)
    );

    tof_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .push_ready (push_ready),
        .pop        (pop),
        .pop_valid  (pop_valid),
        .pop_entry  (pop_entry)
    );

    tof_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (pop_valid),
        .q_entry        (pop_entry),
        .q_pop          (pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_byte     (m_out_byte),
        .m_has_byte     (m_has_byte),
        .m_echo_request (m_echo_request),
        .m_last         (m_last)
    );

endmodule

// ----- src/tof_front.sv -----
// Front end: accepts input bytes, runs the telnet command parser and the
// line counter, and pushes classified entries. Depends on tof_pkg.
module tof_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [7:0]         cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_in_byte,
    input  logic               q_ready,
    output logic               q_push,
    output tof_pkg::tof_entry_t q_entry
);
    import tof_pkg::*;

    localparam logic [2:0] ST_DATA = 3'd0;
    localparam logic [2:0] ST_IAC  = 3'd1;
    localparam logic [2:0] ST_WILL = 3'd2;
    localparam logic [2:0] ST_WONT = 3'd3;
    localparam logic [2:0] ST_DO   = 3'd4;
    localparam logic [2:0] ST_DONT = 3'd5;

    logic       telnet_mode_reg;
    logic [7:0] max_line_reg;
    logic [2:0] state_reg, state_next;
    logic [7:0] prev_reg;
    logic [7:0] count_reg, count_next;

    logic       accept;
    logic       is_data;
    logic [1:0] echo;
    logic [2:0] parse_state;
    logic [7:0] count_inc;

    assign s_ready = q_ready;
    assign accept  = s_valid && q_ready;
    assign count_inc = count_reg + 8'd1;

    always_comb begin
        parse_state = ST_DATA;
        is_data     = 1'b0;
        echo        = ECHO_NONE;
        case (state_reg)
            ST_IAC: begin
                if (s_in_byte == CMD_WILL) begin
                    parse_state = ST_WILL;
                end else if (s_in_byte == CMD_WONT) begin
                    parse_state = ST_WONT;
                end else if (s_in_byte == CMD_DO) begin
                    parse_state = ST_DO;
                end else if (s_in_byte == CMD_DONT) begin
                    parse_state = ST_DONT;
                end else begin
                    // doubled IAC passes as data
                    is_data = (s_in_byte == CMD_IAC);
                end
            end
            ST_WILL, ST_WONT: begin
                parse_state = ST_DATA;
            end
            ST_DO: begin
                if (s_in_byte == OPT_ECHO) begin
                    echo = ECHO_ON;
                end
            end
            ST_DONT: begin
                if (s_in_byte == OPT_ECHO) begin
                    echo = ECHO_OFF;
                end
            end
            default: begin
                if (s_in_byte == CMD_IAC) begin
                    parse_state = ST_IAC;
                end else begin
                    is_data = 1'b1;
                end
            end
        endcase
        if (!telnet_mode_reg) begin
            // raw mode: parser state holds
            parse_state = state_reg;
            is_data     = 1'b1;
            echo        = ECHO_NONE;
        end
    end

    always_comb begin
        state_next = parse_state;
        count_next = count_reg;
        q_push     = 1'b0;
        q_entry    = '{out_byte: s_in_byte, has_byte: 1'b1,
                       echo_request: ECHO_NONE, add_lf: 1'b0};
        if (!is_data) begin
            q_push  = (echo != ECHO_NONE);
            q_entry = '{out_byte: CH_NUL, has_byte: 1'b0,
                        echo_request: echo, add_lf: 1'b0};
        end else if (prev_reg == CH_CR && (s_in_byte == CH_NUL || s_in_byte == CH_LF)) begin
            q_push = 1'b0;
        end else if (s_in_byte == CH_CR || s_in_byte == CH_LF) begin
            q_push     = 1'b1;
            count_next = '0;
        end else if (count_inc >= max_line_reg) begin
            q_push         = 1'b1;
            q_entry.add_lf = 1'b1;
            count_next     = '0;
        end else begin
            q_push     = 1'b1;
            count_next = count_inc;
        end
        if (!accept) begin
            q_push = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            telnet_mode_reg <= 1'b0;
            max_line_reg    <= MAX_LINE_RESET;
            state_reg       <= ST_DATA;
            prev_reg        <= CH_NUL;
            count_reg       <= '0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == CFG_TELNET_MODE) begin
                    telnet_mode_reg <= cfg_wdata[0];
                end else begin
                    max_line_reg <= cfg_wdata;
                end
            end
            if (accept) begin
                state_reg <= state_next;
                prev_reg  <= s_in_byte;
                count_reg <= count_next;
            end
        end
    end

endmodule

// ----- src/tof_queue.sv -----
// Short register queue between the front and back ends.
// Depends on tof_pkg for the entry type and depth.
module tof_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  tof_pkg::tof_entry_t push_entry,
    output logic                push_ready,
    input  logic                pop,
    output logic                pop_valid,
    output tof_pkg::tof_entry_t pop_entry
);
    import tof_pkg::*;

    tof_entry_t         entries_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;
    logic               do_push, do_pop;

    assign push_ready = (count_reg != QCNT_W'(QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = entries_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ----- src/tof_back.sv -----
// Back end: drains queue entries into the output register and inserts the
// forced line feed after a byte that reached the line limit. Depends on tof_pkg.
module tof_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    input  tof_pkg::tof_entry_t q_entry,
    output logic                q_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [7:0]          m_out_byte,
    output logic                m_has_byte,
    output logic [1:0]          m_echo_request,
    output logic                m_last
);
    import tof_pkg::*;

    logic       valid_reg, valid_next;
    logic       lf_pending_reg, lf_pending_next;
    logic [7:0] byte_reg, byte_next;
    logic       has_reg, has_next;
    logic [1:0] echo_reg, echo_next;
    logic       last_reg, last_next;
    logic       load;

    assign load = !valid_reg || m_ready;

    always_comb begin
        valid_next      = valid_reg;
        lf_pending_next = lf_pending_reg;
        byte_next       = byte_reg;
        has_next        = has_reg;
        echo_next       = echo_reg;
        last_next       = last_reg;
        q_pop           = 1'b0;
        if (load) begin
            if (lf_pending_reg) begin
                // emit the forced line feed
                valid_next      = 1'b1;
                lf_pending_next = 1'b0;
                byte_next       = CH_LF;
                has_next        = 1'b1;
                echo_next       = ECHO_NONE;
                last_next       = 1'b1;
            end else if (q_valid) begin
                q_pop           = 1'b1;
                valid_next      = 1'b1;
                lf_pending_next = q_entry.add_lf;
                byte_next       = q_entry.out_byte;
                has_next        = q_entry.has_byte;
                echo_next       = q_entry.echo_request;
                last_next       = !q_entry.add_lf;
            end else begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= 1'b0;
            lf_pending_reg <= 1'b0;
        end else begin
            valid_reg      <= valid_next;
            lf_pending_reg <= lf_pending_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
        has_reg  <= has_next;
        echo_reg <= echo_next;
        last_reg <= last_next;
    end

    assign m_valid        = valid_reg;
    assign m_out_byte     = byte_reg;
    assign m_has_byte     = has_reg;
    assign m_echo_request = echo_reg;
    assign m_last         = last_reg;

endmodule
